[sv/assert_macros.svh]
// Assertion macros used by the checker module of the block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMIT_ASSERT_IMPL(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RMIT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[sv/rmit_pkg.sv]
// Types and constants for the range minimum index tree.
// Depends on nothing; used by the controller, datapath, top level and checker.
package rmit_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int LEAVES_DEF = 1024;
    localparam logic [VAL_W-1:0] SENTINEL = '1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] right_index;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VAL_W-1:0] min_value;
        logic [IDX_W-1:0] min_index;
        logic             none_found;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LD_UPD,
        OP_LD_QRY,
        OP_CLR_LEAF,
        OP_CLR_RD0,
        OP_CLR_RD1,
        OP_CLR_WR,
        OP_UPD_STEP,
        OP_QRY_L,
        OP_QRY_R
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_CLR_LEAF,
        ST_CLR_RD0,
        ST_CLR_RD1,
        ST_CLR_WR,
        ST_IDLE,
        ST_UPD,
        ST_QRY_L,
        ST_QRY_R,
        ST_QRY_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic upd_ok;
        logic is_query;
        logic clr_last_leaf;
        logic at_one;
        logic parent_is_root;
        logic qry_end;
        logic out_free;
    } t_dp_status;

endpackage

[sv/range_min_index_tree.sv]
// Range minimum index tree: a bottom-up segment tree in one node memory of
// 2*LEAVES entries, each node holding the least (value, leaf index) pair below
// it. After reset a clearing pass writes the sentinel tree while input is
// stalled. A write transaction climbs one tree level per cycle through the
// memory's read and write ports; a write to a leaf beyond the tree is accepted
// and dropped. A query transaction may visit two nodes per tree level through
// the single read port, and its result then sits in an output register while
// the next transaction is taken.
// Depends on rmit_pkg, rmit_ctrl and rmit_dp.
module range_min_index_tree #(
    parameter int LEAVES = rmit_pkg::LEAVES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rmit_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rmit_pkg::t_out_item o_out_data
);

    rmit_pkg::t_dp_cmd    dp_cmd;
    rmit_pkg::t_dp_status dp_status;

    rmit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    rmit_dp #(
        .Leaves (LEAVES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/rmit_ctrl.sv]
// Sequencing state machine for the range minimum index tree.
// Depends on rmit_pkg; drives the datapath through command and status structs.
module rmit_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rmit_pkg::t_dp_status i_status,
    output rmit_pkg::t_dp_cmd    o_cmd
);

    rmit_pkg::t_state r_state;
    rmit_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmit_pkg::ST_CLR_LEAF;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = rmit_pkg::OP_NONE;
        o_cmd.out_load = 1'b0;
        o_in_stall     = 1'b1;
        case (r_state)
            rmit_pkg::ST_CLR_LEAF: begin
                o_cmd.op = rmit_pkg::OP_CLR_LEAF;
                if (i_status.clr_last_leaf) begin
                    n_state = rmit_pkg::ST_CLR_RD0;
                end
            end
            rmit_pkg::ST_CLR_RD0: begin
                o_cmd.op = rmit_pkg::OP_CLR_RD0;
                n_state  = rmit_pkg::ST_CLR_RD1;
            end
            rmit_pkg::ST_CLR_RD1: begin
                o_cmd.op = rmit_pkg::OP_CLR_RD1;
                n_state  = rmit_pkg::ST_CLR_WR;
            end
            rmit_pkg::ST_CLR_WR: begin
                o_cmd.op = rmit_pkg::OP_CLR_WR;
                if (i_status.at_one) begin
                    n_state = rmit_pkg::ST_IDLE;
                end else begin
                    n_state = rmit_pkg::ST_CLR_RD0;
                end
            end
            rmit_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_status.is_query) begin
                        o_cmd.op = rmit_pkg::OP_LD_QRY;
                        n_state  = rmit_pkg::ST_QRY_L;
                    end else if (i_status.upd_ok) begin
                        o_cmd.op = rmit_pkg::OP_LD_UPD;
                        n_state  = rmit_pkg::ST_UPD;
                    end
                end
            end
            rmit_pkg::ST_UPD: begin
                o_cmd.op = rmit_pkg::OP_UPD_STEP;
                if (i_status.parent_is_root) begin
                    n_state = rmit_pkg::ST_IDLE;
                end
            end
            rmit_pkg::ST_QRY_L: begin
                o_cmd.op = rmit_pkg::OP_QRY_L;
                if (i_status.qry_end) begin
                    n_state = rmit_pkg::ST_QRY_DONE;
                end else begin
                    n_state = rmit_pkg::ST_QRY_R;
                end
            end
            rmit_pkg::ST_QRY_R: begin
                o_cmd.op = rmit_pkg::OP_QRY_R;
                n_state  = rmit_pkg::ST_QRY_L;
            end
            rmit_pkg::ST_QRY_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rmit_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rmit_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/rmit_dp.sv]
// Datapath of the range minimum index tree: node memory, tree pointers,
// running minimum and output register. Depends on rmit_pkg.
module rmit_dp #(
    parameter int Leaves = rmit_pkg::LEAVES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmit_pkg::t_in_item   i_in_data,
    input  rmit_pkg::t_dp_cmd    i_cmd,
    output rmit_pkg::t_dp_status o_status,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output rmit_pkg::t_out_item  o_out_data
);

    localparam int IdxW  = rmit_pkg::IDX_W;
    localparam int ValW  = rmit_pkg::VAL_W;
    localparam int Depth = 2 * Leaves;
    localparam int LeafW = $clog2(Leaves);
    localparam int NodeW = $clog2(Depth);
    localparam int PtrW  = NodeW + 1;
    localparam int CmpW  = (PtrW > IdxW) ? PtrW : IdxW;

    logic [ValW-1:0]  mem_val [0:Depth-1];
    logic [LeafW-1:0] mem_idx [0:Depth-1];

    logic [PtrW-1:0]  r_lo;
    logic [PtrW-1:0]  r_hi;
    logic [PtrW-1:0]  n_lo;
    logic [PtrW-1:0]  n_hi;
    logic             r_pend;
    logic             n_pend;
    logic             r_have;
    logic [ValW-1:0]  r_acc_val;
    logic [LeafW-1:0] r_acc_idx;
    logic [ValW-1:0]  r_rd_val;
    logic [LeafW-1:0] r_rd_idx;
    logic             r_out_valid;
    rmit_pkg::t_out_item r_out_data;

    logic [CmpW-1:0]  index_e;
    logic [CmpW-1:0]  right_e;
    logic [CmpW-1:0]  leaves_e;
    logic [CmpW-1:0]  right_c;
    logic             upd_ok;
    logic             qry_empty;
    logic [PtrW-1:0]  leaf_ptr;
    logic [PtrW-1:0]  qry_hi;
    logic [PtrW-1:0]  parent;
    logic             take_rd;
    logic [ValW-1:0]  mrg_val;
    logic [LeafW-1:0] mrg_idx;

    logic             rd_en;
    logic [NodeW-1:0] rd_addr;
    logic             wr_en;
    logic [NodeW-1:0] wr_addr;
    logic [ValW-1:0]  wr_val;
    logic [LeafW-1:0] wr_idx;

    assign index_e   = CmpW'(i_in_data.index);
    assign right_e   = CmpW'(i_in_data.right_index);
    assign leaves_e  = CmpW'(Leaves);
    assign upd_ok    = index_e < leaves_e;
    assign right_c   = (right_e >= leaves_e) ? (leaves_e - CmpW'(1)) : right_e;
    assign qry_empty = !upd_ok || (index_e > right_c);
    assign leaf_ptr  = PtrW'(index_e + leaves_e);
    assign qry_hi    = PtrW'(right_c + leaves_e + CmpW'(1));
    assign parent    = r_lo >> 1;

    // Pairs order by value first and leaf index second.
    assign take_rd = !r_have || (r_rd_val < r_acc_val)
                     || ((r_rd_val == r_acc_val) && (r_rd_idx < r_acc_idx));
    assign mrg_val = take_rd ? r_rd_val : r_acc_val;
    assign mrg_idx = take_rd ? r_rd_idx : r_acc_idx;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_val  = mrg_val;
        wr_idx  = mrg_idx;
        n_lo    = r_lo;
        n_hi    = r_hi;
        case (i_cmd.op)
            rmit_pkg::OP_LD_UPD: begin
                rd_en   = 1'b1;
                rd_addr = NodeW'(leaf_ptr) ^ NodeW'(1);
                wr_en   = 1'b1;
                wr_addr = NodeW'(leaf_ptr);
                wr_val  = i_in_data.value;
                wr_idx  = LeafW'(i_in_data.index);
                n_lo    = leaf_ptr;
            end
            rmit_pkg::OP_LD_QRY: begin
                n_lo = qry_empty ? '0 : leaf_ptr;
                n_hi = qry_empty ? '0 : qry_hi;
            end
            rmit_pkg::OP_CLR_LEAF: begin
                wr_en   = 1'b1;
                wr_addr = NodeW'(r_lo);
                wr_val  = rmit_pkg::SENTINEL;
                wr_idx  = LeafW'(r_lo - PtrW'(Leaves));
                n_lo    = r_lo - PtrW'(1);
            end
            rmit_pkg::OP_CLR_RD0: begin
                rd_en   = 1'b1;
                rd_addr = NodeW'({r_lo, 1'b0});
            end
            rmit_pkg::OP_CLR_RD1: begin
                rd_en   = 1'b1;
                rd_addr = NodeW'({r_lo, 1'b1});
            end
            rmit_pkg::OP_CLR_WR: begin
                wr_en   = 1'b1;
                wr_addr = NodeW'(r_lo);
                n_lo    = r_lo - PtrW'(1);
            end
            rmit_pkg::OP_UPD_STEP: begin
                wr_en   = 1'b1;
                wr_addr = NodeW'(parent);
                rd_en   = parent != PtrW'(1);
                rd_addr = NodeW'(parent) ^ NodeW'(1);
                n_lo    = parent;
            end
            rmit_pkg::OP_QRY_L: begin
                if ((r_lo < r_hi) && r_lo[0]) begin
                    rd_en   = 1'b1;
                    rd_addr = NodeW'(r_lo);
                    n_lo    = r_lo + PtrW'(1);
                end
            end
            rmit_pkg::OP_QRY_R: begin
                if (r_hi[0]) begin
                    rd_en   = 1'b1;
                    rd_addr = NodeW'(r_hi - PtrW'(1));
                end
                n_lo = r_lo >> 1;
                n_hi = r_hi >> 1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
        n_pend = rd_en;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[wr_addr] <= wr_val;
            mem_idx[wr_addr] <= wr_idx;
        end
        if (rd_en) begin
            r_rd_val <= mem_val[rd_addr];
            r_rd_idx <= mem_idx[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo        <= PtrW'(Depth - 1);
            r_hi        <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_pend <= n_pend;
            if (i_cmd.op == rmit_pkg::OP_LD_UPD) begin
                r_have <= 1'b1;
            end else if ((i_cmd.op == rmit_pkg::OP_LD_QRY)
                         || (i_cmd.op == rmit_pkg::OP_CLR_RD0)) begin
                r_have <= 1'b0;
            end else if (r_pend) begin
                r_have <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rmit_pkg::OP_LD_UPD) begin
            r_acc_val <= i_in_data.value;
            r_acc_idx <= LeafW'(i_in_data.index);
        end else if ((i_cmd.op == rmit_pkg::OP_LD_QRY)
                     || (i_cmd.op == rmit_pkg::OP_CLR_RD0)) begin
            r_acc_val <= rmit_pkg::SENTINEL;
            r_acc_idx <= '0;
        end else if (r_pend) begin
            r_acc_val <= mrg_val;
            r_acc_idx <= mrg_idx;
        end
        if (i_cmd.out_load) begin
            r_out_data.none_found <= !r_have;
            r_out_data.min_value  <= r_have ? r_acc_val : rmit_pkg::SENTINEL;
            r_out_data.min_index  <= r_have ? IdxW'(r_acc_idx) : '0;
        end
    end

    assign o_status.upd_ok         = upd_ok;
    assign o_status.is_query       = i_in_data.command == rmit_pkg::CMD_QUERY;
    assign o_status.clr_last_leaf  = r_lo == PtrW'(Leaves);
    assign o_status.at_one         = r_lo == PtrW'(1);
    assign o_status.parent_is_root = parent == PtrW'(1);
    assign o_status.qry_end        = !(r_lo < r_hi);
    assign o_status.out_free       = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[sv/rmit_checker.sv]
// Port-level checks for the range minimum index tree, bound to the top level.
// Depends on rmit_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmit_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input rmit_pkg::t_out_item o_out_data
);

    `RMIT_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `RMIT_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `RMIT_ASSERT_IMPL(a_empty_result, i_clk, i_rst_n, o_out_valid && o_out_data.none_found, (o_out_data.min_value == rmit_pkg::SENTINEL) && (o_out_data.min_index == '0))
    `RMIT_ASSERT_IMPL(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), o_in_stall)
    `RMIT_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, !$rose(o_out_valid))

endmodule

bind range_min_index_tree rmit_checker u_rmit_checker (.*);

[tb/range_min_checker.sv]
// Checker for the range minimum index tree: watches both channels, keeps a leaf
// model, predicts each query result and compares it field by field.
// Depends on rmit_pkg.
module range_min_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  rmit_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  rmit_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int LEAVES = rmit_pkg::LEAVES_DEF;
    localparam int IdxW   = rmit_pkg::IDX_W;
    localparam int ValW   = rmit_pkg::VAL_W;

    logic [ValW-1:0]     leaf_value [LEAVES];
    rmit_pkg::t_out_item expected_minima [$];
    int                  result_count;

    function automatic rmit_pkg::t_out_item range_minimum(input logic [IdxW-1:0] lo,
                                                          input logic [IdxW-1:0] hi);
        rmit_pkg::t_out_item best;
        int                  k;
        best.min_value  = rmit_pkg::SENTINEL;
        best.min_index  = '0;
        best.none_found = 1'b1;
        if (lo > hi) begin
            return best;
        end
        best.min_value  = leaf_value[lo];
        best.min_index  = lo;
        best.none_found = 1'b0;
        for (k = int'(lo) + 1; k <= int'(hi); k++) begin
            if (leaf_value[k] < best.min_value) begin
                best.min_value = leaf_value[k];
                best.min_index = IdxW'(k);
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        rmit_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int k = 0; k < LEAVES; k++) begin
                leaf_value[k] = rmit_pkg::SENTINEL;
            end
            expected_minima.delete();
            o_fail_count = 0;
            result_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_minima.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result: value %h index %0d none %0b",
                                 i_out_data.min_value, i_out_data.min_index,
                                 i_out_data.none_found);
                    end
                end else begin
                    want = expected_minima.pop_front();
                    if (i_out_data.min_value !== want.min_value
                            || i_out_data.min_index !== want.min_index
                            || i_out_data.none_found !== want.none_found) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("result %0d: expected value %h index %0d none %0b, %s",
                                     result_count, want.min_value, want.min_index,
                                     want.none_found, "got:");
                            $display("    value %h index %0d none %0b",
                                     i_out_data.min_value, i_out_data.min_index,
                                     i_out_data.none_found);
                        end
                    end
                end
                result_count++;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.command == rmit_pkg::CMD_WRITE) begin
                    leaf_value[i_in_data.index] = i_in_data.value;
                end else begin
                    expected_minima = {expected_minima,
                                       range_minimum(i_in_data.index,
                                                     i_in_data.right_index)};
                end
            end
        end
        o_pending = expected_minima.size();
    end

endmodule

[tb/tb_range_min_index_tree.sv]
// Testbench top for the range minimum index tree: drives directed and random
// write and query transactions with random idling on both channels.
// Depends on rmit_pkg, range_min_index_tree and range_min_checker.
module tb_range_min_index_tree;

    localparam int IdxW = rmit_pkg::IDX_W;
    localparam int ValW = rmit_pkg::VAL_W;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    rmit_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    rmit_pkg::t_out_item o_out_data;

    int        fail_count;
    int        pending_count;
    bit        no_gaps;
    int        hold_off_cycles;

    range_min_index_tree DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    range_min_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_item(input rmit_pkg::t_in_item item);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic take_results();
        int n;
        forever begin
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                n = no_gaps ? 0 : $urandom_range(0, 11);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    endtask

    function automatic rmit_pkg::t_in_item random_transaction(input bit query_only);
        rmit_pkg::t_in_item item;
        int                 lo;
        int                 hi;
        lo = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
        item.command     = (query_only || $urandom_range(0, 99) < 55) ? rmit_pkg::CMD_QUERY
                                                                      : rmit_pkg::CMD_WRITE;
        item.index       = IdxW'(lo);
        item.right_index = IdxW'($urandom());
        case ($urandom_range(0, 9))
            0:       item.value = rmit_pkg::SENTINEL;
            1:       item.value = '0;
            2, 3, 4: item.value = ValW'($urandom_range(0, 15));
            default: item.value = ValW'($urandom());
        endcase
        if (item.command == rmit_pkg::CMD_QUERY) begin
            case ($urandom_range(0, 5))
                0, 1: hi = lo + $urandom_range(0, 15);
                2:    hi = $urandom_range(0, 1023);
                3: begin
                    lo = 0;
                    hi = 1023;
                end
                4:    hi = (lo > 0) ? $urandom_range(0, lo - 1) : $urandom_range(0, 1023);
                default: hi = lo + $urandom_range(0, 300);
            endcase
            if (hi > 1023) begin
                hi = 1023;
            end
            item.index       = IdxW'(lo);
            item.right_index = IdxW'(hi);
        end
        return item;
    endfunction

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_out_stall     = 1'b0;
        no_gaps         = 1'b0;
        hold_off_cycles = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_results();
        join_none

        send_item('{rmit_pkg::CMD_QUERY, 10'd0, 10'd1023, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd5, 10'd5, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd10, 10'd3, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1023, 10'd0, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1023, 10'd1023, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'd0, 10'h3FF, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'd1023, 10'h155, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'd512, 10'h2AA, 32'd7});
        send_item('{rmit_pkg::CMD_WRITE, 10'd300, 10'd0, 32'd7});
        send_item('{rmit_pkg::CMD_QUERY, 10'd0, 10'd1023, 32'hFFFF_FFFF});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1, 10'd1023, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1, 10'd1022, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'd300, 10'd0, rmit_pkg::SENTINEL});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1, 10'd1022, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'h2AA, 10'd0, 32'hAAAA_AAAA});
        send_item('{rmit_pkg::CMD_WRITE, 10'h155, 10'd0, 32'h5555_5555});
        send_item('{rmit_pkg::CMD_WRITE, 10'd1000, 10'd0, 32'hFFFF_FFFE});
        send_item('{rmit_pkg::CMD_QUERY, 10'd1000, 10'd1000, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'h155, 10'h2AA, 32'h0});
        send_item('{rmit_pkg::CMD_QUERY, 10'd301, 10'd511, 32'h0});
        send_item('{rmit_pkg::CMD_WRITE, 10'd0, 10'd0, rmit_pkg::SENTINEL});
        send_item('{rmit_pkg::CMD_QUERY, 10'd0, 10'd0, 32'h0});

        for (int i = 0; i < 1590; i++) begin
            no_gaps = (i >= 300 && i < 500) || (i >= 1200 && i < 1260);
            if (i == 800) begin
                no_gaps         = 1'b1;
                hold_off_cycles = 400;
                repeat (40) send_item(random_transaction(1'b1));
                no_gaps         = 1'b0;
            end
            send_item(random_transaction(1'b0));
        end
        i_in_valid <= 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/rmit_pkg.sv
sv/rmit_ctrl.sv
sv/rmit_dp.sv
sv/range_min_index_tree.sv
sv/rmit_checker.sv
tb/range_min_checker.sv
tb/tb_range_min_index_tree.sv
